### sv/receive_descriptor_ring_manager_unit_defines.svh
// ----------------------------------------------------------------------------
// Receive descriptor ring manager assertion macros
// Shared assertion forms for the ring manager top level.
// ----------------------------------------------------------------------------
`ifndef RECEIVE_DESCRIPTOR_RING_MANAGER_UNIT_DEFINES_SVH
`define RECEIVE_DESCRIPTOR_RING_MANAGER_UNIT_DEFINES_SVH

// same-cycle implication
`define RDRM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RDRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rdrm_pkg.sv
// ----------------------------------------------------------------------------
// Receive descriptor ring manager package
// Field widths, request and status codes, controller types.
// ----------------------------------------------------------------------------
package rdrm_pkg;

    localparam int RING_SLOTS_DEF   = 64;
    localparam int BUFFER_BYTES_DEF = 48128;

    localparam int REQ_TYPE_W = 2;
    localparam int SIZE_W     = 16;
    localparam int STATUS_W   = 3;
    localparam int SLOT_W     = 6;
    localparam int REMAIN_W   = 7;
    localparam int MAX_OS_W   = 6;

    localparam logic [MAX_OS_W-1:0] MAX_OS_RESET = 6'd16;

    localparam logic [REQ_TYPE_W-1:0] REQ_ISSUE    = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_COMPLETE = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_TAKE     = 2'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_PURGE    = 2'd3;

    localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STS_REFUSED  = 3'd1;
    localparam logic [STATUS_W-1:0] STS_PENDING  = 3'd2;
    localparam logic [STATUS_W-1:0] STS_ERROR    = 3'd3;
    localparam logic [STATUS_W-1:0] STS_NO_READY = 3'd4;

    typedef enum logic
    {
        STATE_IDLE,
        STATE_EXEC
    } rdrm_state_t;

    typedef struct packed
    {
        logic latch;
        logic commit;
    } rdrm_cmd_t;

    typedef struct packed
    {
        logic out_free;
    } rdrm_sts_t;

endpackage

### sv/rdrm_req_if.sv
// ----------------------------------------------------------------------------
// Ring manager request channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface rdrm_req_if
    import rdrm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [SIZE_W-1:0]     received_size;
    logic                  still_pending;
    logic                  receive_failed;

    modport source
    (
        output valid, req_type, received_size, still_pending, receive_failed,
        input  ready
    );

    modport sink
    (
        input  valid, req_type, received_size, still_pending, receive_failed,
        output ready
    );
endinterface

### sv/rdrm_rsp_if.sv
// ----------------------------------------------------------------------------
// Ring manager result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface rdrm_rsp_if
    import rdrm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [SIZE_W-1:0]   data_size;
    logic [REMAIN_W-1:0] remaining;
    logic                skipped;
    logic                purged;

    modport source
    (
        output valid, status, slot_index, data_size, remaining, skipped, purged,
        input  ready
    );

    modport sink
    (
        input  valid, status, slot_index, data_size, remaining, skipped, purged,
        output ready
    );
endinterface

### sv/rdrm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rdrm_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/rdrm_ctrl.sv
// ----------------------------------------------------------------------------
// Ring manager controller
// Sequences accept and execute of one request word at a time.
// ----------------------------------------------------------------------------
module rdrm_ctrl
    import rdrm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output rdrm_cmd_t cmd,
    input  rdrm_sts_t sts
);

    rdrm_state_t state_reg;
    rdrm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            STATE_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = STATE_EXEC;
                end
            end
            STATE_EXEC:
            begin
                if (sts.out_free)
                begin
                    state_next = STATE_IDLE;
                end
            end
            default:
            begin
                state_next = STATE_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.latch  = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            STATE_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            STATE_EXEC:
            begin
                cmd.commit = sts.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

### sv/rdrm_datapath.sv
// ----------------------------------------------------------------------------
// Ring manager datapath
// Pointers, counts, posted flags, slot-size RAM and result register.
// ----------------------------------------------------------------------------
module rdrm_datapath
    import rdrm_pkg::*;
#(
    parameter int RING_SLOTS   = RING_SLOTS_DEF,
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [MAX_OS_W-1:0]   cfg_write_data,
    input  logic [REQ_TYPE_W-1:0] req_type,
    input  logic [SIZE_W-1:0]     received_size,
    input  logic                  still_pending,
    input  logic                  receive_failed,
    input  rdrm_cmd_t             cmd,
    output rdrm_sts_t             sts,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic [STATUS_W-1:0]   status,
    output logic [SLOT_W-1:0]     slot_index,
    output logic [SIZE_W-1:0]     data_size,
    output logic [REMAIN_W-1:0]   remaining,
    output logic                  skipped,
    output logic                  purged
);

    localparam int PW = $clog2(RING_SLOTS);
    localparam int CW = $clog2(RING_SLOTS + 1);
    localparam int KW = ((CW > MAX_OS_W) ? CW : MAX_OS_W) + 1;

    localparam logic [PW-1:0]     LAST_SLOT = PW'(RING_SLOTS - 1);
    localparam logic [CW-1:0]     SLOTS_C   = CW'(RING_SLOTS);
    localparam logic [CW:0]       SLOTS_S   = (CW + 1)'(RING_SLOTS);
    localparam logic [SIZE_W-1:0] BUF_MAX   = SIZE_W'(BUFFER_BYTES);

    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + PW'(1);
    endfunction

    logic [MAX_OS_W-1:0]   max_os_reg;
    logic [PW-1:0]         issue_ptr_reg, issue_ptr_next;
    logic [PW-1:0]         complete_ptr_reg, complete_ptr_next;
    logic [PW-1:0]         take_ptr_reg, take_ptr_next;
    logic [CW-1:0]         busy_reg, busy_next;
    logic [CW-1:0]         ready_reg, ready_next;
    logic [PW-1:0]         held_slot_reg, held_slot_next;
    logic                  held_valid_reg, held_valid_next;
    logic [RING_SLOTS-1:0] posted_reg, posted_next;

    logic [REQ_TYPE_W-1:0] req_type_reg;
    logic [SIZE_W-1:0]     rsize_reg;
    logic                  pending_reg;
    logic                  failed_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [PW-1:0]         slot_reg, slot_next;
    logic [SIZE_W-1:0]     dsize_reg, dsize_next;
    logic [CW-1:0]         remain_reg, remain_next;
    logic                  skip_reg, skip_next;
    logic                  purge_reg, purge_next;

    logic                  ram_we;
    logic [SIZE_W-1:0]     ram_wdata;
    logic [SIZE_W-1:0]     ram_rdata;

    logic                  refuse;
    logic                  ring_full;
    logic [PW-1:0]         issue_adv;
    logic                  cur_posted;
    logic [SIZE_W-1:0]     clamped;

    rdrm_ram
    #(
        .WIDTH (SIZE_W),
        .DEPTH (RING_SLOTS)
    )
    u_size_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (complete_ptr_reg),
        .wdata (ram_wdata),
        .raddr (take_ptr_reg),
        .rdata (ram_rdata)
    );

    assign refuse     = (KW'(busy_reg) >= KW'(max_os_reg)) || (busy_reg >= SLOTS_C);
    assign ring_full  = ({1'b0, ready_reg} + {1'b0, busy_reg}) >= SLOTS_S;
    assign issue_adv  = next_slot(issue_ptr_reg);
    assign cur_posted = posted_reg[complete_ptr_reg];
    assign clamped    = (rsize_reg > BUF_MAX) ? BUF_MAX : rsize_reg;
    assign sts.out_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        issue_ptr_next    = issue_ptr_reg;
        complete_ptr_next = complete_ptr_reg;
        take_ptr_next     = take_ptr_reg;
        busy_next         = busy_reg;
        ready_next        = ready_reg;
        held_slot_next    = held_slot_reg;
        held_valid_next   = held_valid_reg;
        posted_next       = posted_reg;
        ram_we            = 1'b0;
        ram_wdata         = '0;
        status_next       = STS_OK;
        slot_next         = '0;
        dsize_next        = '0;
        remain_next       = '0;
        skip_next         = 1'b0;
        purge_next        = 1'b0;
        case (req_type_reg)
            REQ_ISSUE:
            begin
                if (refuse)
                begin
                    status_next = STS_REFUSED;
                end
                else
                begin
                    if (ring_full)
                    begin
                        take_ptr_next = complete_ptr_reg;
                        ready_next    = '0;
                        purge_next    = 1'b1;
                    end
                    issue_ptr_next = issue_adv;
                    busy_next      = busy_reg + CW'(1);
                    slot_next      = issue_adv;
                    if (held_valid_reg && (held_slot_reg == issue_adv))
                    begin
                        posted_next[issue_adv] = 1'b0;
                        skip_next              = 1'b1;
                    end
                    else
                    begin
                        posted_next[issue_adv] = 1'b1;
                    end
                end
            end
            REQ_COMPLETE:
            begin
                if (busy_reg == '0)
                begin
                    status_next = STS_REFUSED;
                end
                else
                begin
                    slot_next = complete_ptr_reg;
                    if (cur_posted && pending_reg)
                    begin
                        status_next = STS_PENDING;
                    end
                    else if (cur_posted && failed_reg)
                    begin
                        status_next                   = STS_ERROR;
                        posted_next[complete_ptr_reg] = 1'b0;
                    end
                    else
                    begin
                        ram_we                        = 1'b1;
                        ram_wdata                     = cur_posted ? clamped : '0;
                        posted_next[complete_ptr_reg] = 1'b0;
                        complete_ptr_next             = next_slot(complete_ptr_reg);
                        busy_next                     = busy_reg - CW'(1);
                        ready_next                    = ready_reg + CW'(1);
                        dsize_next                    = cur_posted ? clamped : '0;
                    end
                end
            end
            REQ_TAKE:
            begin
                if (ready_reg != '0)
                begin
                    slot_next       = take_ptr_reg;
                    dsize_next      = ram_rdata;
                    held_slot_next  = take_ptr_reg;
                    held_valid_next = ram_rdata != '0;
                    take_ptr_next   = next_slot(take_ptr_reg);
                    ready_next      = ready_reg - CW'(1);
                    remain_next     = ready_reg - CW'(1);
                end
                else
                begin
                    status_next     = STS_NO_READY;
                    held_valid_next = 1'b0;
                end
            end
            REQ_PURGE:
            begin
                take_ptr_next = complete_ptr_reg;
                ready_next    = '0;
                purge_next    = 1'b1;
            end
            default:
            begin
                status_next = STS_OK;
            end
        endcase
        if (!cmd.commit)
        begin
            ram_we = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp_ready;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_os_reg       <= MAX_OS_RESET;
            issue_ptr_reg    <= '0;
            complete_ptr_reg <= PW'(1);
            take_ptr_reg     <= PW'(1);
            busy_reg         <= '0;
            ready_reg        <= '0;
            held_slot_reg    <= '0;
            held_valid_reg   <= 1'b0;
            posted_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                max_os_reg <= cfg_write_data;
            end
            if (cmd.commit)
            begin
                issue_ptr_reg    <= issue_ptr_next;
                complete_ptr_reg <= complete_ptr_next;
                take_ptr_reg     <= take_ptr_next;
                busy_reg         <= busy_next;
                ready_reg        <= ready_next;
                held_slot_reg    <= held_slot_next;
                held_valid_reg   <= held_valid_next;
                posted_reg       <= posted_next;
            end
        end
    end

    // request and result words
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_type_reg <= req_type;
            rsize_reg    <= received_size;
            pending_reg  <= still_pending;
            failed_reg   <= receive_failed;
        end
        if (cmd.commit)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            dsize_reg  <= dsize_next;
            remain_reg <= remain_next;
            skip_reg   <= skip_next;
            purge_reg  <= purge_next;
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot_index = SLOT_W'(slot_reg);
    assign data_size  = dsize_reg;
    assign remaining  = REMAIN_W'(remain_reg);
    assign skipped    = skip_reg;
    assign purged     = purge_reg;

endmodule

### sv/receive_descriptor_ring_manager_unit.sv
// ----------------------------------------------------------------------------
// Receive descriptor ring manager top level
// Request word latched on accept in IDLE; result registered on commit in EXEC, delayed by stall.
// One request at a time: accept, then execute with slot-size RAM read data; no accept in EXEC.
// Reset: asynchronous; issue pointer 0, complete/take pointers 1, counts, held, posted cleared.
// ----------------------------------------------------------------------------
`include "receive_descriptor_ring_manager_unit_defines.svh"

module receive_descriptor_ring_manager_unit
    import rdrm_pkg::*;
#(
    parameter int RING_SLOTS   = RING_SLOTS_DEF,
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [MAX_OS_W-1:0] cfg_write_data,
    rdrm_req_if.sink            req,
    rdrm_rsp_if.source          rsp
);

    rdrm_cmd_t cmd;
    rdrm_sts_t sts;

    rdrm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    rdrm_datapath
    #(
        .RING_SLOTS   (RING_SLOTS),
        .BUFFER_BYTES (BUFFER_BYTES)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .req_type       (req.req_type),
        .received_size  (req.received_size),
        .still_pending  (req.still_pending),
        .receive_failed (req.receive_failed),
        .cmd            (cmd),
        .sts            (sts),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .status         (rsp.status),
        .slot_index     (rsp.slot_index),
        .data_size      (rsp.data_size),
        .remaining      (rsp.remaining),
        .skipped        (rsp.skipped),
        .purged         (rsp.purged)
    );

    `RDRM_ASSERT_NOW(a_commit_free, clk, rst_n, cmd.commit, sts.out_free, "commit into busy output")
    `RDRM_ASSERT_NEXT(a_commit_shows, clk, rst_n, cmd.commit, rsp.valid, "committed word not shown")
    `RDRM_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req.valid && req.ready, !req.ready, "accepted during execute")
    `RDRM_ASSERT_NOW(a_latch_on_accept, clk, rst_n, req.valid && req.ready, cmd.latch, "word not latched")

endmodule

### bench/rdrm_ring_checker.sv
// ----------------------------------------------------------------------------
// Ring manager result checker
// Watches the register port and both channels. Every accepted request word is
// run through a private model of the three pointer ring. The expected result
// word is queued and compared field by field with the next result word the
// block hands out.
// ----------------------------------------------------------------------------
module rdrm_ring_checker
    import rdrm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [MAX_OS_W-1:0] cfg_write_data,
    rdrm_req_if                 req,
    rdrm_rsp_if                 rsp,
    output int unsigned         mismatches,
    output int unsigned         owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_SLOTS   = RING_SLOTS_DEF;
    localparam int BUFFER_BYTES = BUFFER_BYTES_DEF;

    typedef struct packed
    {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
        logic [SIZE_W-1:0]   data_size;
        logic [REMAIN_W-1:0] remaining;
        logic                skipped;
        logic                purged;
    } ring_result_t;

    logic [MAX_OS_W-1:0] limit_reg;
    logic [SLOT_W-1:0]   issue_ptr;
    logic [SLOT_W-1:0]   done_ptr;
    logic [SLOT_W-1:0]   take_ptr;
    logic [REMAIN_W-1:0] busy_cnt;
    logic [REMAIN_W-1:0] ready_cnt;
    logic [SLOT_W-1:0]   held_idx;
    logic                held_on;
    logic                posted_map [RING_SLOTS];
    logic [SIZE_W-1:0]   size_map [RING_SLOTS];
    ring_result_t        owed_results [$];

    function automatic logic [SLOT_W-1:0] step_slot(input logic [SLOT_W-1:0] p);
        return (int'(p) + 1 >= RING_SLOTS) ? '0 : p + 1'b1;
    endfunction

    function automatic ring_result_t ring_outcome(
        input logic [REQ_TYPE_W-1:0] kind,
        input logic [SIZE_W-1:0]     rx_size,
        input logic                  pend,
        input logic                  fail
    );
        ring_result_t      r;
        logic [SLOT_W-1:0] c;
        logic [SIZE_W-1:0] sz;
        logic              done;
        r = '0;
        case (kind)
            REQ_ISSUE:
            begin
                if (busy_cnt >= limit_reg || int'(busy_cnt) >= RING_SLOTS)
                begin
                    r.status = STS_REFUSED;
                end
                else
                begin
                    if (int'(ready_cnt) + int'(busy_cnt) >= RING_SLOTS)
                    begin
                        take_ptr  = done_ptr;
                        ready_cnt = '0;
                        r.purged  = 1'b1;
                    end
                    issue_ptr    = step_slot(issue_ptr);
                    busy_cnt     = busy_cnt + 1'b1;
                    r.slot_index = issue_ptr;
                    if (held_on && held_idx == issue_ptr)
                    begin
                        posted_map[issue_ptr] = 1'b0;
                        r.skipped = 1'b1;
                    end
                    else
                    begin
                        posted_map[issue_ptr] = 1'b1;
                    end
                end
            end
            REQ_COMPLETE:
            begin
                if (busy_cnt == 0)
                begin
                    r.status = STS_REFUSED;
                end
                else
                begin
                    c    = done_ptr;
                    done = 1'b1;
                    sz   = '0;
                    if (posted_map[c])
                    begin
                        if (pend)
                        begin
                            r.status = STS_PENDING;
                            done = 1'b0;
                        end
                        else if (fail)
                        begin
                            r.status = STS_ERROR;
                            posted_map[c] = 1'b0;
                            done = 1'b0;
                        end
                        else
                        begin
                            sz = (rx_size > BUFFER_BYTES) ? SIZE_W'(BUFFER_BYTES) : rx_size;
                        end
                    end
                    r.slot_index = c;
                    if (done)
                    begin
                        size_map[c]   = sz;
                        posted_map[c] = 1'b0;
                        done_ptr      = step_slot(c);
                        busy_cnt      = busy_cnt - 1'b1;
                        ready_cnt     = ready_cnt + 1'b1;
                        r.data_size   = sz;
                    end
                end
            end
            REQ_TAKE:
            begin
                if (ready_cnt != 0)
                begin
                    r.slot_index = take_ptr;
                    r.data_size  = size_map[take_ptr];
                    held_idx     = take_ptr;
                    held_on      = (r.data_size != 0);
                    take_ptr     = step_slot(take_ptr);
                    ready_cnt    = ready_cnt - 1'b1;
                    r.remaining  = ready_cnt;
                end
                else
                begin
                    r.status = STS_NO_READY;
                    held_on  = 1'b0;
                end
            end
            REQ_PURGE:
            begin
                take_ptr  = done_ptr;
                ready_cnt = '0;
                r.purged  = 1'b1;
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ring_result_t want;
        ring_result_t got;
        if (!rst_n)
        begin
            limit_reg  = MAX_OS_RESET;
            issue_ptr  = '0;
            done_ptr   = SLOT_W'(1);
            take_ptr   = SLOT_W'(1);
            busy_cnt   = '0;
            ready_cnt  = '0;
            held_idx   = '0;
            held_on    = 1'b0;
            for (int i = 0; i < RING_SLOTS; i++)
            begin
                posted_map[i] = 1'b0;
                size_map[i]   = '0;
            end
            owed_results.delete();
            mismatches = 0;
            owed       = 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                limit_reg = cfg_write_data;
            end
            if (rsp.valid && rsp.ready)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("result word with no request awaiting it");
                    mismatches++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    got  = '{rsp.status, rsp.slot_index, rsp.data_size, rsp.remaining,
                             rsp.skipped, rsp.purged};
                    check_field("status", want.status, got.status);
                    check_field("slot_index", want.slot_index, got.slot_index);
                    check_field("data_size", want.data_size, got.data_size);
                    check_field("remaining", want.remaining, got.remaining);
                    check_field("skipped", want.skipped, got.skipped);
                    check_field("purged", want.purged, got.purged);
                end
            end
            if (req.valid && req.ready)
            begin
                owed_results.push_back(ring_outcome(req.req_type, req.received_size,
                                                    req.still_pending, req.receive_failed));
            end
            owed = owed_results.size();
        end
    end

endmodule

### bench/receive_descriptor_ring_manager_unit_tb.sv
// ----------------------------------------------------------------------------
// Receive descriptor ring manager testbench
// Drives a directed opening and then phases of random request words under
// several outstanding limits, with random idling on both channels and one
// long result stall. The checker beside the block predicts every result word.
// ----------------------------------------------------------------------------
module receive_descriptor_ring_manager_unit_tb;
    import rdrm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                clk;
    logic                rst_n;
    logic                cfg_write_en;
    logic [MAX_OS_W-1:0] cfg_write_data;
    int unsigned         mismatches;
    int unsigned         owed;
    int unsigned         sent_in_phase;
    bit                  calm;
    bit                  pressure_go;
    bit                  pressure_done;

    rdrm_req_if req_ch();
    rdrm_rsp_if rsp_ch();

    receive_descriptor_ring_manager_unit i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .req            (req_ch),
        .rsp            (rsp_ch)
    );

    rdrm_ring_checker i_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .mismatches     (mismatches),
        .owed           (owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [SIZE_W-1:0] draw_size();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return SIZE_W'(BUFFER_BYTES_DEF);
            2:       return SIZE_W'($urandom_range(BUFFER_BYTES_DEF + 1, 65535));
            3:       return '1;
            4:       return SIZE_W'($urandom_range(1, 64));
            default: return SIZE_W'($urandom_range(0, BUFFER_BYTES_DEF));
        endcase
    endfunction

    task automatic offer(input logic [REQ_TYPE_W-1:0] kind, input logic [SIZE_W-1:0] size,
                         input logic pend, input logic fail);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= kind;
        req_ch.received_size  <= size;
        req_ch.still_pending  <= pend;
        req_ch.receive_failed <= fail;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        @(negedge clk);
        sent_in_phase++;
    endtask

    task automatic offer_noise();
        offer(REQ_TYPE_W'($urandom_range(0, 3)), SIZE_W'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic offer_complete();
        offer(REQ_COMPLETE, draw_size(), $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (owed != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_limit(input logic [MAX_OS_W-1:0] value);
        drain();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    task automatic busy_round();
        int n;
        n = $urandom_range(1, 8);
        repeat (n) offer(REQ_ISSUE, SIZE_W'($urandom), 1'($urandom), 1'($urandom));
        repeat (n + $urandom_range(0, 1)) offer_complete();
        repeat ($urandom_range(0, n + 1)) offer(REQ_TAKE, SIZE_W'($urandom), 1'($urandom),
                                                 1'($urandom));
        if ($urandom_range(0, 9) == 0)
        begin
            offer(REQ_PURGE, SIZE_W'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    // fill the ring without taking so that issue wraps onto the held slot
    task automatic flood_ring();
        offer(REQ_PURGE, SIZE_W'($urandom), 1'($urandom), 1'($urandom));
        repeat (8)
        begin
            offer(REQ_ISSUE, SIZE_W'($urandom), 1'($urandom), 1'($urandom));
            offer(REQ_COMPLETE, SIZE_W'($urandom_range(1, BUFFER_BYTES_DEF)), 1'b0, 1'b0);
        end
        offer(REQ_TAKE, SIZE_W'($urandom), 1'($urandom), 1'($urandom));
        repeat ($urandom_range(66, 72))
        begin
            offer(REQ_ISSUE, SIZE_W'($urandom), 1'($urandom), 1'($urandom));
            offer(REQ_COMPLETE, draw_size(), $urandom_range(0, 7) == 0,
                  $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic run_phase(input int unsigned budget, input bit with_flood);
        sent_in_phase = 0;
        if (with_flood)
        begin
            flood_ring();
        end
        while (sent_in_phase < budget)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 4)) offer_noise();
            end
            else
            begin
                busy_round();
            end
        end
    endtask

    initial
    begin
        int unsigned hold;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (pressure_go && !pressure_done)
            begin
                rsp_ch.ready <= 1'b0;
                hold = 0;
                while (hold < 200)
                begin
                    @(negedge clk);
                    hold++;
                end
                pressure_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        cfg_write_en          = 1'b0;
        cfg_write_data        = '0;
        req_ch.valid          = 1'b0;
        req_ch.req_type       = REQ_ISSUE;
        req_ch.received_size  = '0;
        req_ch.still_pending  = 1'b0;
        req_ch.receive_failed = 1'b0;
        calm                  = 1'b0;
        pressure_go           = 1'b0;
        pressure_done         = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        offer(REQ_TAKE, '1, 1'b1, 1'b1);
        offer(REQ_COMPLETE, '1, 1'b0, 1'b0);
        offer(REQ_PURGE, '0, 1'b0, 1'b0);
        repeat (4) offer(REQ_ISSUE, '0, 1'b0, 1'b0);
        offer(REQ_COMPLETE, 16'd100, 1'b1, 1'b1);
        offer(REQ_COMPLETE, 16'd100, 1'b0, 1'b1);
        offer(REQ_COMPLETE, 16'd100, 1'b1, 1'b0);
        offer(REQ_COMPLETE, '1, 1'b0, 1'b0);
        offer(REQ_COMPLETE, SIZE_W'(BUFFER_BYTES_DEF + 1), 1'b0, 1'b0);
        offer(REQ_COMPLETE, SIZE_W'(BUFFER_BYTES_DEF), 1'b0, 1'b0);
        offer(REQ_COMPLETE, '0, 1'b0, 1'b0);
        offer(REQ_TAKE, '0, 1'b0, 1'b0);
        offer(REQ_TAKE, '0, 1'b0, 1'b0);
        offer(REQ_PURGE, '1, 1'b1, 1'b1);
        offer(REQ_TAKE, '0, 1'b0, 1'b0);
        offer(REQ_ISSUE, '1, 1'b1, 1'b1);
        offer(REQ_COMPLETE, '0, 1'b0, 1'b0);
        offer(REQ_TAKE, '0, 1'b0, 1'b0);

        set_limit(6'd1);
        run_phase(50, 1'b0);
        set_limit(6'd63);
        run_phase(160, 1'b1);
        set_limit(6'd0);
        run_phase(20, 1'b0);
        set_limit(MAX_OS_W'($urandom_range(2, 62)));
        pressure_go = 1'b1;
        run_phase(100, 1'b0);
        set_limit(6'd63);
        calm = 1'b1;
        run_phase(160, 1'b1);

        drain();
        repeat (10) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
